FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, muted while rst_n is low.
`define MSCQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, live during reset too.
`define MSCQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mscq_pkg.sv
// ----------------------------------------------------------------------------
// Marching squares quad package
// Field widths, the case-to-edge table and the edge-to-corner table.
// ----------------------------------------------------------------------------
package mscq_pkg;

  localparam int COORD_W      = 14;
  localparam int SCALAR_W     = 32;
  localparam int OUT_W        = 22;
  localparam int DIFF_W       = SCALAR_W + 1;
  localparam int DEF_FRAC_BITS = 8;
  localparam int NUM_EDGES    = 4;
  localparam int NUM_LANES    = 2 * NUM_EDGES;

  typedef logic [1:0] edge_id_t;
  typedef logic [1:0] corner_id_t;

  // Segments per case: bit 0 -> first segment present, bit 1 -> second.
  typedef struct packed {
    logic seg1;
    logic seg0;
  } seg_mask_t;

  // Edges per case in emit order; unused slots are masked by seg_mask_t.
  localparam edge_id_t CASE_EDGE [16][4] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0}, '{2'd1, 2'd3, 2'd0, 2'd0},
    '{2'd1, 2'd2, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd1, 2'd2},
    '{2'd0, 2'd2, 2'd0, 2'd0}, '{2'd2, 2'd3, 2'd0, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd0}, '{2'd0, 2'd2, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd2, 2'd0, 2'd0},
    '{2'd1, 2'd3, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd3, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0, 2'd0}
  };

  localparam corner_id_t EDGE_END [4][2] = '{
    '{2'd0, 2'd1}, '{2'd1, 2'd2}, '{2'd3, 2'd2}, '{2'd0, 2'd3}
  };

  localparam logic [3:0] CASE_NONE_LO = 4'h0;
  localparam logic [3:0] CASE_NONE_HI = 4'hf;
  localparam logic [3:0] CASE_SADDLE_A = 4'h5;
  localparam logic [3:0] CASE_SADDLE_B = 4'ha;

endpackage

FILE: hdl/mscq_if.sv
// ----------------------------------------------------------------------------
// Marching squares quad channels
// Valid/ready channels for quads in and segments out.
// ----------------------------------------------------------------------------
interface mscq_in_if import mscq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [COORD_W-1:0]         corner0_x, corner0_y;
  logic signed [SCALAR_W-1:0] corner0_value;
  logic [COORD_W-1:0]         corner1_x, corner1_y;
  logic signed [SCALAR_W-1:0] corner1_value;
  logic [COORD_W-1:0]         corner2_x, corner2_y;
  logic signed [SCALAR_W-1:0] corner2_value;
  logic [COORD_W-1:0]         corner3_x, corner3_y;
  logic signed [SCALAR_W-1:0] corner3_value;

  modport source (
    output valid, corner0_x, corner0_y, corner0_value, corner1_x, corner1_y,
           corner1_value, corner2_x, corner2_y, corner2_value, corner3_x,
           corner3_y, corner3_value,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner0_value, corner1_x, corner1_y,
           corner1_value, corner2_x, corner2_y, corner2_value, corner3_x,
           corner3_y, corner3_value,
    output ready
  );
endinterface

interface mscq_out_if import mscq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] start_x, start_y, end_x, end_y;
  logic             final_segment;

  modport source (
    output valid, start_x, start_y, end_x, end_y, final_segment,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, final_segment,
    output ready
  );
endinterface

FILE: hdl/mscq_edge_sel.sv
// ----------------------------------------------------------------------------
// Marching squares edge setup
// Classify the quad and register per-lane operands for the edge cuts.
// ----------------------------------------------------------------------------
module mscq_edge_sel import mscq_pkg::*; (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SCALAR_W-1:0] iso,
  input  logic [COORD_W-1:0]         cx [4],
  input  logic [COORD_W-1:0]         cy [4],
  input  logic signed [SCALAR_W-1:0] cs [4],
  output logic [DIFF_W-1:0]          num_mag_r [NUM_LANES],
  output logic [DIFF_W-1:0]          den_mag_r [NUM_LANES],
  output logic [COORD_W-1:0]         dp_mag_r  [NUM_LANES],
  output logic [COORD_W-1:0]         pa_r      [NUM_LANES],
  output logic                       neg_r     [NUM_LANES],
  output seg_mask_t                  mask_r
);

  logic [3:0]                cidx;
  seg_mask_t                 mask_nxt;
  logic [DIFF_W-1:0]         num_mag_nxt [NUM_LANES];
  logic [DIFF_W-1:0]         den_mag_nxt [NUM_LANES];
  logic [COORD_W-1:0]        dp_mag_nxt  [NUM_LANES];
  logic [COORD_W-1:0]        pa_nxt      [NUM_LANES];
  logic                      neg_nxt     [NUM_LANES];

  always_comb begin
    edge_id_t           ed;
    corner_id_t         ca, cb;
    logic [DIFF_W-1:0]  num, den;
    logic [COORD_W-1:0] pa, pb;
    logic [COORD_W:0]   dp;
    for (int i = 0; i < 4; i++) begin
      cidx[i] = cs[i] > iso;
    end
    mask_nxt.seg0 = (cidx != CASE_NONE_LO) && (cidx != CASE_NONE_HI);
    mask_nxt.seg1 = (cidx == CASE_SADDLE_A) || (cidx == CASE_SADDLE_B);
    for (int j = 0; j < NUM_EDGES; j++) begin
      ed  = CASE_EDGE[cidx][j];
      ca  = EDGE_END[ed][0];
      cb  = EDGE_END[ed][1];
      num = {iso[SCALAR_W-1], iso} - {cs[ca][SCALAR_W-1], cs[ca]};
      den = {cs[cb][SCALAR_W-1], cs[cb]} - {cs[ca][SCALAR_W-1], cs[ca]};
      for (int c = 0; c < 2; c++) begin
        pa = (c == 0) ? cx[ca] : cy[ca];
        pb = (c == 0) ? cx[cb] : cy[cb];
        dp = {1'b0, pb} - {1'b0, pa};
        num_mag_nxt[2*j+c] = num[DIFF_W-1] ? -num : num;
        den_mag_nxt[2*j+c] = den[DIFF_W-1] ? -den : den;
        dp_mag_nxt[2*j+c]  = dp[COORD_W] ? COORD_W'(-dp) : dp[COORD_W-1:0];
        pa_nxt[2*j+c]      = pa;
        neg_nxt[2*j+c]     = num[DIFF_W-1] ^ den[DIFF_W-1] ^ dp[COORD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask_r    <= mask_nxt;
      num_mag_r <= num_mag_nxt;
      den_mag_r <= den_mag_nxt;
      dp_mag_r  <= dp_mag_nxt;
      pa_r      <= pa_nxt;
      neg_r     <= neg_nxt;
    end
  end

endmodule

FILE: hdl/mscq_cut_lane.sv
// ----------------------------------------------------------------------------
// Marching squares cut lane
// One coordinate of one edge cut: multiply, pipelined divide, round, offset.
// ----------------------------------------------------------------------------
module mscq_cut_lane import mscq_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  localparam int QB = COORD_W + FRAC_BITS,
  localparam int NS = QB + 2
) (
  input  logic               clk,
  input  logic [NS-1:0]      st_en,
  input  logic [DIFF_W-1:0]  num_mag,
  input  logic [DIFF_W-1:0]  den_mag,
  input  logic [COORD_W-1:0] dp_mag,
  input  logic [COORD_W-1:0] pa,
  input  logic               neg,
  output logic [OUT_W-1:0]   res
);

  localparam int MW = DIFF_W + COORD_W + FRAC_BITS;
  localparam int RW = QB + 2;
  localparam int XW = ((RW > OUT_W) ? RW : OUT_W) + 1;

  logic [MW-1:0]      rem_r [QB+1];
  logic [DIFF_W-1:0]  d_r   [QB+1];
  logic [QB-1:0]      q_r   [QB+1];
  logic [COORD_W-1:0] pa_r  [QB+1];
  logic               neg_r [QB+1];

  logic [QB:0]        qf_r;
  logic [COORD_W-1:0] pf_r;
  logic               nf_r;

  // Scale the product up front so the quotient carries the fraction bits.
  always_ff @(posedge clk) begin
    if (st_en[0]) begin
      rem_r[0] <= MW'(num_mag * dp_mag) << FRAC_BITS;
      d_r[0]   <= den_mag;
      q_r[0]   <= '0;
      pa_r[0]  <= pa;
      neg_r[0] <= neg;
    end
  end

  // One quotient bit per stage, MSB first.
  for (genvar s = 0; s < QB; s++) begin : g_div
    localparam int BIT = QB - 1 - s;
    logic [MW-1:0] dsh;
    logic [MW:0]   diff;
    assign dsh  = MW'(d_r[s]) << BIT;
    assign diff = {1'b0, rem_r[s]} - {1'b0, dsh};
    always_ff @(posedge clk) begin
      if (st_en[s+1]) begin
        rem_r[s+1] <= diff[MW] ? rem_r[s] : diff[MW-1:0];
        q_r[s+1]   <= q_r[s] | (QB'(!diff[MW]) << BIT);
        d_r[s+1]   <= d_r[s];
        pa_r[s+1]  <= pa_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  // Round to nearest, ties away from zero.
  logic [DIFF_W-1:0] rr;
  logic              rnd;
  assign rr  = rem_r[QB][DIFF_W-1:0];
  assign rnd = rr >= (d_r[QB] - rr);

  always_ff @(posedge clk) begin
    if (st_en[QB+1]) begin
      qf_r <= {1'b0, q_r[QB]} + (QB+1)'(rnd);
      pf_r <= pa_r[QB];
      nf_r <= neg_r[QB];
    end
  end

  logic [XW-1:0] base, qx, sum;
  always_comb begin
    base = XW'(pf_r) << FRAC_BITS;
    qx   = XW'(qf_r);
    if (nf_r) begin
      sum = (qx > base) ? '0 : base - qx;
    end else begin
      sum = base + qx;
    end
    res = (sum > XW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : sum[OUT_W-1:0];
  end

endmodule

FILE: hdl/mscq_out_ser.sv
// ----------------------------------------------------------------------------
// Marching squares output serializer
// Drop degenerate segments, then send the quad's segments one per cycle while out_seg.ready allows.
// ----------------------------------------------------------------------------
module mscq_out_ser import mscq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_v,
  input  seg_mask_t        mask,
  input  logic [OUT_W-1:0] lane_res [NUM_LANES],
  output logic             load,
  mscq_out_if.source       out_seg
);

  logic [1:0]       pm_r, pm_after, keep;
  logic [OUT_W-1:0] seg_r [2][4];
  logic             ov_r, emit0, emit1, free;

  always_comb begin
    keep[0] = mask.seg0 && !(lane_res[0] == lane_res[2] && lane_res[1] == lane_res[3]);
    keep[1] = mask.seg1 && !(lane_res[4] == lane_res[6] && lane_res[5] == lane_res[7]);
    free     = !ov_r || out_seg.ready;
    emit0    = pm_r[0] && free;
    emit1    = !pm_r[0] && pm_r[1] && free;
    pm_after = pm_r & ~{emit1, emit0};
    load     = (pm_after == 2'b00);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= '0;
      ov_r <= 1'b0;
    end else begin
      pm_r <= (load && in_v) ? keep : pm_after;
      if (emit0 || emit1) begin
        ov_r <= 1'b1;
      end else if (out_seg.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_v) begin
      for (int s = 0; s < 2; s++) begin
        for (int f = 0; f < 4; f++) begin
          seg_r[s][f] <= lane_res[4*s+f];
        end
      end
    end
    if (emit0 || emit1) begin
      out_seg.start_x       <= seg_r[emit1][0];
      out_seg.start_y       <= seg_r[emit1][1];
      out_seg.end_x         <= seg_r[emit1][2];
      out_seg.end_y         <= seg_r[emit1][3];
      out_seg.final_segment <= emit1 || !pm_r[1];
    end
  end

  assign out_seg.valid = ov_r;

endmodule

FILE: hdl/marching_squares_quad_unit.sv
// ----------------------------------------------------------------------------
// Marching squares quad unit
// Turns one dual-grid quad into up to two iso-contour line segments.
// ----------------------------------------------------------------------------
// Usage:
//   in_quad  : valid/ready request carrying four corner positions and values.
//   out_seg  : valid/ready request per segment; final_segment marks the last
//              segment of its quad. Quads with no surviving segment emit none.
//   cfg_wr_* : write iso_level while the unit is idle.
// Pipeline: from quad accept to first segment a quad passes the setup stage
//   (loaded at the accepting edge), then one multiply stage, one divide
//   stage per quotient bit, a rounding stage, the serializer buffer and
//   the output register.
// Throughput: a quad enters every cycle unless the output stalls; the single
//   output channel drains one segment per cycle, so two-segment saddle quads set the pace.
// Reset: clears all stage valid bits, the serializer and iso_level (to 0).
// Stall: a low out_seg.ready holds the output register; bubbles in the
//   pipeline still fill, and in_quad.ready drops only once every stage ahead
//   is occupied. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module marching_squares_quad_unit import mscq_pkg::*; #(
  parameter int OUT_FRACTION_BITS = DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [SCALAR_W-1:0] cfg_wr_data,
  mscq_in_if.sink             in_quad,
  mscq_out_if.source          out_seg
);

  localparam int QB = COORD_W + OUT_FRACTION_BITS;
  // Stages: setup, multiply, QB divide steps, round.
  localparam int NV = QB + 3;

  logic signed [SCALAR_W-1:0] iso_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= '0;
    end else if (cfg_wr_en) begin
      iso_r <= cfg_wr_data;
    end
  end

  // Stage valid bits; a stage loads when it is empty or its content moves on.
  logic [NV-1:0] v_r;
  logic [NV:0]   ld;
  logic          ser_load;

  always_comb begin
    ld[NV] = ser_load;
    for (int k = NV - 1; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NV; k++) begin
        if (ld[k]) begin
          v_r[k] <= (k == 0) ? in_quad.valid : v_r[k-1];
        end
      end
    end
  end

  assign in_quad.ready = ld[0];

  // Gather corners for the setup stage.
  logic [COORD_W-1:0]         cx [4];
  logic [COORD_W-1:0]         cy [4];
  logic signed [SCALAR_W-1:0] cs [4];

  assign cx = '{in_quad.corner0_x, in_quad.corner1_x, in_quad.corner2_x, in_quad.corner3_x};
  assign cy = '{in_quad.corner0_y, in_quad.corner1_y, in_quad.corner2_y, in_quad.corner3_y};
  assign cs = '{in_quad.corner0_value, in_quad.corner1_value,
                in_quad.corner2_value, in_quad.corner3_value};

  logic [DIFF_W-1:0]  num_mag [NUM_LANES];
  logic [DIFF_W-1:0]  den_mag [NUM_LANES];
  logic [COORD_W-1:0] dp_mag  [NUM_LANES];
  logic [COORD_W-1:0] pa      [NUM_LANES];
  logic               neg     [NUM_LANES];
  seg_mask_t          mask0_r;

  mscq_edge_sel u_edge_sel (
    .clk       (clk),
    .en        (ld[0]),
    .iso       (iso_r),
    .cx        (cx),
    .cy        (cy),
    .cs        (cs),
    .num_mag_r (num_mag),
    .den_mag_r (den_mag),
    .dp_mag_r  (dp_mag),
    .pa_r      (pa),
    .neg_r     (neg),
    .mask_r    (mask0_r)
  );

  // Carry the segment mask alongside the lanes.
  seg_mask_t mask_r [NV];
  assign mask_r[0] = mask0_r;

  for (genvar k = 1; k < NV; k++) begin : g_mask
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        mask_r[k] <= mask_r[k-1];
      end
    end
  end

  // Lanes: edge j, coordinate c -> lane 2*j + c.
  logic [OUT_W-1:0] lane_res [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    mscq_cut_lane #(
      .FRAC_BITS (OUT_FRACTION_BITS)
    ) u_lane (
      .clk     (clk),
      .st_en   (ld[NV-1:1]),
      .num_mag (num_mag[l]),
      .den_mag (den_mag[l]),
      .dp_mag  (dp_mag[l]),
      .pa      (pa[l]),
      .neg     (neg[l]),
      .res     (lane_res[l])
    );
  end

  mscq_out_ser u_out_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v_r[NV-1]),
    .mask     (mask_r[NV-1]),
    .lane_res (lane_res),
    .load     (ser_load),
    .out_seg  (out_seg)
  );

endmodule

FILE: hdl/mscq_chk.sv
// ----------------------------------------------------------------------------
// Marching squares quad checker
// Port-level checks on the segment channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mscq_chk import mscq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] start_x,
  input logic [OUT_W-1:0] start_y,
  input logic [OUT_W-1:0] end_x,
  input logic [OUT_W-1:0] end_y,
  input logic             final_segment
);

  `MSCQ_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_valid, "segment valid right after reset")
  `MSCQ_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid, "stalled segment dropped")
  `MSCQ_ASSERT(a_no_degenerate, out_valid |-> !(start_x == end_x && start_y == end_y), "degenerate segment sent")
  `MSCQ_ASSERT(a_pair_follows, out_valid && out_ready && !final_segment |=> out_valid, "second segment of quad late")
  `MSCQ_ASSERT(a_ready_reset, !rst_n |=> !(in_valid && in_ready && out_valid), "activity out of reset")

endmodule

bind marching_squares_quad_unit mscq_chk u_mscq_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_quad.valid),
  .in_ready      (in_quad.ready),
  .out_valid     (out_seg.valid),
  .out_ready     (out_seg.ready),
  .start_x       (out_seg.start_x),
  .start_y       (out_seg.start_y),
  .end_x         (out_seg.end_x),
  .end_y         (out_seg.end_y),
  .final_segment (out_seg.final_segment)
);
